// ===== hw/rtl/tmwm_pkg.sv =====
// ----------------------------------------------------------------------------
// tmwm_pkg
// Shared beat types, cell codes and the sequencer program for the toroidal
// masked window mean block.
// ----------------------------------------------------------------------------
package tmwm_pkg;

  localparam int FIELD_W    = 7;
  localparam int IN_TRAIT_W = 16;
  localparam int OUT_MEAN_W = 16;
  localparam int COUNT_W    = 5;
  localparam int CODE_W     = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int PC_W       = 3;
  localparam int COND_W     = 3;

  localparam logic [FIELD_W-1:0] DIM_MIN   = 7'd3;
  localparam logic [FIELD_W-1:0] DIM_RESET = 7'd64;

  localparam logic [COUNT_W-1:0] MAX_ALIVE = 5'd24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 4'd1;

  // actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // cell codes
  localparam logic [CODE_W-1:0] CODE_A1 = 3'd1;
  localparam logic [CODE_W-1:0] CODE_B2 = 3'd2;
  localparam logic [CODE_W-1:0] CODE_A3 = 3'd3;
  localparam logic [CODE_W-1:0] CODE_B4 = 3'd4;

  // program steps
  localparam logic [PC_W-1:0] S_CLEAR = 3'd0;
  localparam logic [PC_W-1:0] S_IDLE  = 3'd1;
  localparam logic [PC_W-1:0] S_CHECK = 3'd2;
  localparam logic [PC_W-1:0] S_SCAN  = 3'd3;
  localparam logic [PC_W-1:0] S_DRAIN = 3'd4;
  localparam logic [PC_W-1:0] S_LOAD  = 3'd5;
  localparam logic [PC_W-1:0] S_DIV   = 3'd6;
  localparam logic [PC_W-1:0] S_EMIT  = 3'd7;

  // jump conditions
  localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
  localparam logic [COND_W-1:0] C_CLR_MORE = 3'd2;
  localparam logic [COND_W-1:0] C_NO_QUERY = 3'd3;
  localparam logic [COND_W-1:0] C_BAD      = 3'd4;
  localparam logic [COND_W-1:0] C_WIN_MORE = 3'd5;
  localparam logic [COND_W-1:0] C_DIV_MORE = 3'd6;

  typedef struct packed {
    logic                  action;
    logic [FIELD_W-1:0]    row;
    logic [FIELD_W-1:0]    col;
    logic [CODE_W-1:0]     cell_code;
    logic [IN_TRAIT_W-1:0] trait_a;
    logic [IN_TRAIT_W-1:0] trait_b;
  } in_item_t;

  typedef struct packed {
    logic [OUT_MEAN_W-1:0] mean_trait;
    logic [COUNT_W-1:0]    alive_neighbours;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic              clr_wr;
    logic              idle;
    logic              issue;
    logic              div_load;
    logic              div_step;
    logic              emit;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } uc_t;

  function automatic uc_t uc_rom(input logic [PC_W-1:0] pc);
    uc_t w;
    w = '0;
    unique case (pc)
      S_CLEAR: begin
        w.clr_wr = 1'b1; w.cond = C_CLR_MORE; w.target = S_CLEAR;
      end
      S_IDLE: begin
        w.idle = 1'b1; w.cond = C_NO_QUERY; w.target = S_IDLE;
      end
      S_CHECK: begin
        w.cond = C_BAD; w.target = S_EMIT;
      end
      S_SCAN: begin
        w.issue = 1'b1; w.cond = C_WIN_MORE; w.target = S_SCAN;
      end
      S_DRAIN: begin
        w.cond = C_NEVER; w.target = S_LOAD;
      end
      S_LOAD: begin
        w.div_load = 1'b1; w.cond = C_NEVER; w.target = S_DIV;
      end
      S_DIV: begin
        w.div_step = 1'b1; w.cond = C_DIV_MORE; w.target = S_DIV;
      end
      S_EMIT: begin
        w.emit = 1'b1; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/tmwm_divider.sv =====
// ----------------------------------------------------------------------------
// tmwm_divider
// Restoring divider, one quotient bit per step, stepped by the sequencer.
// ----------------------------------------------------------------------------
module tmwm_divider #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tmwm_pkg::div_ctl_t ctl,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic [NUM_W-1:0]   quo,
  output logic               last
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign last    = (cnt_r == CNT_W'(NUM_W - 1));
  assign quo     = quo_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      cnt_nxt = '0;
    end else if (ctl.step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (ctl.step) begin
      if (!diff[DEN_W+1]) begin
        rem_r <= diff[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/toroidal_masked_window_mean.sv =====
// ----------------------------------------------------------------------------
// toroidal_masked_window_mean
// Cell grid with 5x5 toroidal window mean over alive neighbours.
// ----------------------------------------------------------------------------
// in: an item is taken when start is high and busy is low. a write item loads
//   one cell while the sequencer stays idle, so busy stays low and the next item may
//   follow at once. a query item raises busy until its result beat goes out.
// out: one beat per query on out_item, marked by out_valid for one cycle; no
//   beat for writes. the receiver cannot stall, so nothing waits on it.
// cfg: cfg_valid/cfg_ready write rows_in_use (index 0) and cols_in_use
//   (index 1); cfg_ready is always high. write only while busy is low.
// query: a query runs one check step, 25 window reads on the single read
//   port of the cell memory, one drain, one divider load, TRAIT_BITS+5 steps
//   of the restoring divider and one emit step. out_valid is registered from
//   the emit step and busy is low in the cycle that out_valid is high, so a
//   new query can be taken only once the last one has sent its result beat.
//   a centre outside the grid goes from the check step straight to the emit
//   step and has a beat with zero mean and zero alive neighbours.
// reset: both dimensions return to 64 and a clearing pass writes all
//   MAX_ROWS*MAX_COLS cells (4096 by default) of the memory to empty with
//   busy high; configuration writes are taken during the pass.
// ----------------------------------------------------------------------------
module toroidal_masked_window_mean #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int TRAIT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  tmwm_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  output tmwm_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tmwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmwm_pkg::FIELD_W-1:0]        cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = tmwm_pkg::CODE_W + 2 * TRAIT_BITS;
  localparam int SUMW  = TRAIT_BITS + tmwm_pkg::COUNT_W;
  localparam int FW    = tmwm_pkg::FIELD_W;
  localparam int CNTW  = tmwm_pkg::COUNT_W;

  logic [CW-1:0] mem [DEPTH];

  logic [tmwm_pkg::PC_W-1:0] pc_r, pc_nxt;
  tmwm_pkg::uc_t             uc;
  logic                      take;

  logic [FW-1:0]   rows_r, cols_r;
  logic [FW-1:0]   nr_c, nc_c;
  logic [AW-1:0]   clr_r;
  logic [FW-1:0]   row_r, col_r, nr_r, nc_r;
  logic [2:0]      dr_r, dc_r;
  logic [SUMW-1:0] sum_r;
  logic [CNTW-1:0] alive_r;
  logic            rd_pend_r, skip_r;
  logic [CW-1:0]   rd_data_r;
  logic            out_valid_r;
  tmwm_pkg::out_item_t out_item_r;

  logic            accept, wr_ok, qry_ok, win_last;
  logic [7:0]      tr, tc, wr, wc, nr8, nc8;
  logic            centre;
  logic [AW-1:0]   rd_addr, wr_addr, mem_wa;
  logic [CW-1:0]   mem_wd;
  logic            mem_we;

  logic [tmwm_pkg::CODE_W-1:0] rd_code;
  logic [TRAIT_BITS-1:0]       rd_ta, rd_tb, add_val;
  logic                        add_one;

  tmwm_pkg::div_ctl_t div_ctl;
  logic [SUMW-1:0]    quo;
  logic               div_last;

  assign uc        = tmwm_pkg::uc_rom(pc_r);
  assign busy      = !uc.idle;
  assign accept    = start && uc.idle;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // dimension clamp
  always_comb begin
    if (rows_r < tmwm_pkg::DIM_MIN) begin
      nr_c = tmwm_pkg::DIM_MIN;
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      nr_c = FW'(MAX_ROWS);
    end else begin
      nr_c = rows_r;
    end
    if (cols_r < tmwm_pkg::DIM_MIN) begin
      nc_c = tmwm_pkg::DIM_MIN;
    end else if (32'(cols_r) > 32'(MAX_COLS)) begin
      nc_c = FW'(MAX_COLS);
    end else begin
      nc_c = cols_r;
    end
  end

  // window position, wrapped once
  assign nr8 = {1'b0, nr_r};
  assign nc8 = {1'b0, nc_r};
  assign tr  = {1'b0, row_r} + {5'd0, dr_r};
  assign tc  = {1'b0, col_r} + {5'd0, dc_r};

  always_comb begin
    if (tr <= 8'd2) begin
      wr = tr + nr8 - 8'd2;
    end else if (tr > nr8 + 8'd2) begin
      wr = tr - nr8 - 8'd2;
    end else begin
      wr = tr - 8'd2;
    end
    if (tc <= 8'd2) begin
      wc = tc + nc8 - 8'd2;
    end else if (tc > nc8 + 8'd2) begin
      wc = tc - nc8 - 8'd2;
    end else begin
      wc = tc - 8'd2;
    end
  end

  assign centre   = (wr == {1'b0, row_r}) && (wc == {1'b0, col_r});
  assign rd_addr  = AW'(32'(wr - 8'd1) * 32'(MAX_COLS) + 32'(wc - 8'd1));
  assign win_last = (dr_r == 3'd4) && (dc_r == 3'd4);
  assign qry_ok   = (row_r != '0) && (row_r <= nr_r) && (col_r != '0) && (col_r <= nc_r);

  // write beat address
  assign wr_ok   = (in_item.row != '0) && (32'(in_item.row) <= 32'(MAX_ROWS)) &&
                   (in_item.col != '0) && (32'(in_item.col) <= 32'(MAX_COLS));
  assign wr_addr = AW'(32'(in_item.row - FW'(1)) * 32'(MAX_COLS) +
                       32'(in_item.col - FW'(1)));

  assign mem_we = uc.clr_wr ||
                  (accept && (in_item.action == tmwm_pkg::ACT_WRITE) && wr_ok);
  assign mem_wa = uc.clr_wr ? clr_r : wr_addr;
  assign mem_wd = uc.clr_wr ? '0 :
                  {in_item.cell_code, TRAIT_BITS'(in_item.trait_a),
                   TRAIT_BITS'(in_item.trait_b)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    case (uc.cond)
      tmwm_pkg::C_ALWAYS:   take = 1'b1;
      tmwm_pkg::C_CLR_MORE: take = (clr_r != AW'(DEPTH - 1));
      tmwm_pkg::C_NO_QUERY: take = !(start && (in_item.action == tmwm_pkg::ACT_QUERY));
      tmwm_pkg::C_BAD:      take = !qry_ok;
      tmwm_pkg::C_WIN_MORE: take = !win_last;
      tmwm_pkg::C_DIV_MORE: take = !div_last;
      default:              take = 1'b0;
    endcase
    pc_nxt = take ? uc.target : pc_r + tmwm_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= tmwm_pkg::S_CLEAR;
      clr_r       <= '0;
      rows_r      <= tmwm_pkg::DIM_RESET;
      cols_r      <= tmwm_pkg::DIM_RESET;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      rd_pend_r   <= uc.issue;
      out_valid_r <= uc.emit;
      if (uc.clr_wr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tmwm_pkg::REG_ROWS) begin
          rows_r <= cfg_data;
        end else if (cfg_index == tmwm_pkg::REG_COLS) begin
          cols_r <= cfg_data;
        end
      end
    end
  end

  // trait select
  assign rd_code = rd_data_r[CW-1 -: tmwm_pkg::CODE_W];
  assign rd_ta   = rd_data_r[2*TRAIT_BITS-1 -: TRAIT_BITS];
  assign rd_tb   = rd_data_r[TRAIT_BITS-1:0];

  always_comb begin
    add_val = '0;
    add_one = 1'b0;
    case (rd_code) inside
      tmwm_pkg::CODE_A1, tmwm_pkg::CODE_A3: begin
        add_val = rd_ta;
        add_one = 1'b1;
      end
      tmwm_pkg::CODE_B2, tmwm_pkg::CODE_B4: begin
        add_val = rd_tb;
        add_one = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept && (in_item.action == tmwm_pkg::ACT_QUERY)) begin
      row_r   <= in_item.row;
      col_r   <= in_item.col;
      nr_r    <= nr_c;
      nc_r    <= nc_c;
      dr_r    <= '0;
      dc_r    <= '0;
      sum_r   <= '0;
      alive_r <= '0;
    end else begin
      if (uc.issue) begin
        skip_r <= centre;
        if (dc_r == 3'd4) begin
          dc_r <= '0;
          dr_r <= dr_r + 3'd1;
        end else begin
          dc_r <= dc_r + 3'd1;
        end
      end
      if (rd_pend_r && !skip_r) begin
        sum_r   <= sum_r + SUMW'(add_val);
        alive_r <= alive_r + CNTW'(add_one);
      end
    end
    if (uc.emit) begin
      out_item_r.mean_trait       <= (alive_r == '0) ? '0 : tmwm_pkg::OUT_MEAN_W'(quo);
      out_item_r.alive_neighbours <= alive_r;
    end
  end

  assign div_ctl.load = uc.div_load;
  assign div_ctl.step = uc.div_step;

  tmwm_divider #(
    .NUM_W(SUMW),
    .DEN_W(CNTW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .num  (sum_r),
    .den  (alive_r),
    .quo  (quo),
    .last (div_last)
  );

endmodule

// ===== hw/rtl/tmwm_checker.sv =====
// ----------------------------------------------------------------------------
// tmwm_checker
// Port-level checks for the toroidal masked window mean block, bound to it.
// ----------------------------------------------------------------------------
module tmwm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input tmwm_pkg::in_item_t  in_item,
  input logic                out_valid,
  input tmwm_pkg::out_item_t out_item
);

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("busy low right after reset");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.action == tmwm_pkg::ACT_WRITE)) |=> !busy)
    else $error("write beat raised busy");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.action == tmwm_pkg::ACT_QUERY)) |=> (busy && !out_valid))
    else $error("query beat did not raise busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result beat while busy or repeated");

  a_alive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.alive_neighbours <= tmwm_pkg::MAX_ALIVE))
    else $error("alive count beyond window");

endmodule

bind toroidal_masked_window_mean tmwm_checker u_tmwm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);
